// ===== hdl/vgcd_pkg.sv =====
`timescale 1ns / 1ps
package vgcd_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int MAX_CELLS = 4096;
	localparam int PT_AW = $clog2(MAX_POINTS);
	localparam int CNT_W = PT_AW + 1;
	localparam int CELL_AW = $clog2(MAX_CELLS);
	localparam int CELLS_W = CELL_AW + 1;
	localparam int COORD_W = 32;
	localparam int LEAF_W = 31;
	localparam int SUM_W = COORD_W + PT_AW + 1;
	localparam int HITS_W = CNT_W;
	localparam int CFG_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [LEAF_W-1:0] LEAF_RESET = LEAF_W'(65536);
	localparam logic RK_STATUS = 1'b0;
	localparam logic RK_FETCH = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_END,
		CMD_FETCH,
		CMD_SPARE
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_EMPTY,
		ST_OVERFLOW,
		ST_GRID,
		ST_NONE
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LEAF_X,
		REG_LEAF_Y,
		REG_LEAF_Z,
		REG_CUT_EN,
		REG_CUT_DIST
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                command;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic [COORD_W-1:0]        point_distance;
	} req_t;

	typedef struct packed {
		logic                      result_kind;
		logic [2:0]                status;
		logic [CELLS_W-1:0]        centroid_count;
		logic signed [COORD_W-1:0] mean_x;
		logic signed [COORD_W-1:0] mean_y;
		logic signed [COORD_W-1:0] mean_z;
		logic                      last_centroid;
	} res_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_EOS_FAIL,
		OP_EOS_OK,
		OP_PASS_INIT,
		OP_PT_READ,
		OP_DIV_PT,
		OP_BOX_UPD,
		OP_DIM1,
		OP_DIM2,
		OP_COMMIT,
		OP_CLEAR,
		OP_OFFSET,
		OP_IDX1,
		OP_IDX2,
		OP_CELL_READ_IDX,
		OP_CELL_ACC,
		OP_CELL_READ_CUR,
		OP_CELL_CHECK,
		OP_FETCH_EMIT,
		OP_FETCH_NONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} ctl_t;

	typedef struct packed {
		logic ovf;
		logic cnt_zero;
		logic pt_last;
		logic div_done;
		logic grid_big;
		logic clr_last;
		logic hits_nz;
		logic scan_more;
		logic fetch_empty;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_B_READ,
		S_B_DIV,
		S_B_WAIT,
		S_DIM1,
		S_DIM2,
		S_DIM3,
		S_CLEAR,
		S_A_READ,
		S_A_DIV,
		S_A_WAIT,
		S_A_IDX1,
		S_A_IDX2,
		S_A_RD,
		S_A_UPD,
		S_A_DONE,
		S_F_READ,
		S_F_CHECK,
		S_F_WAIT,
		S_F_NONE
	} state_t;

endpackage

// ===== hdl/vgcd_div.sv =====
`timescale 1ns / 1ps
module vgcd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                floor_mode,
	input  logic signed [vgcd_pkg::SUM_W-1:0]   dividend,
	input  logic [vgcd_pkg::LEAF_W-1:0]         divisor,
	output logic                                done,
	output logic [vgcd_pkg::COORD_W-1:0]        quotient
);
	import vgcd_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic              neg_q;
	logic              floor_q;
	logic [SUM_W-1:0]  mag_q;
	logic [LEAF_W-1:0] rem_q;
	logic [LEAF_W-1:0] dvs_q;
	logic [LEAF_W:0]   rem_sh;
	logic [LEAF_W:0]   rem_nx;
	logic              fits;
	logic [COORD_W-1:0] qu;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, mag_q[SUM_W-1]};
	assign fits = rem_sh >= {1'b0, dvs_q};
	assign rem_nx = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
	assign qu = mag_q[COORD_W-1:0];

	// floor of a negative inexact quotient is -q-1 = ~q
	always_comb begin
		if (!neg_q) begin
			quotient = qu;
		end else if (floor_q && (rem_q != '0)) begin
			quotient = ~qu;
		end else begin
			quotient = ~qu + COORD_W'(1);
		end
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(SUM_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			floor_q <= floor_mode;
			mag_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			rem_q <= '0;
			dvs_q <= (divisor == '0) ? LEAF_W'(1) : divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[SUM_W-2:0], fits};
			rem_q <= rem_nx[LEAF_W-1:0];
		end
	end

endmodule

// ===== hdl/vgcd_dp.sv =====
`timescale 1ns / 1ps
module vgcd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vgcd_pkg::req_t                    request,
	input  vgcd_pkg::ctl_t                    ctl,
	input  logic                              write_enable,
	input  logic [vgcd_pkg::REG_IDX_W-1:0]    reg_index,
	input  logic [vgcd_pkg::CFG_W-1:0]        write_data,
	output vgcd_pkg::dp_stat_t                stat,
	output logic                              done,
	output vgcd_pkg::res_t                    result
);
	import vgcd_pkg::*;

	localparam int PT_W = 3 * COORD_W;
	localparam int IDX_W = CELL_AW + CELLS_W;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic [HITS_W-1:0]       hits;
	} cell_t;

	logic [LEAF_W-1:0]         leaf_q [3];
	logic                      cut_en_q;
	logic [COORD_W-1:0]        cut_dist_q;

	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic [PT_W-1:0]           pt_mem [MAX_POINTS];
	logic [PT_W-1:0]           pt_q;
	logic [PT_AW-1:0]          n_q;
	logic signed [COORD_W-1:0] lo_q [3];
	logic signed [COORD_W-1:0] hi_q [3];
	logic [CELLS_W-1:0]        dim_q [3];
	logic                      over_q [3];
	logic [2*CELLS_W-1:0]      p01_q;
	logic [CELLS_W-1:0]        total_q;
	logic [CELL_AW-1:0]        clr_q;
	logic [CELL_AW-1:0]        off_q [3];
	logic [CELL_AW-1:0]        t_q;
	logic [CELL_AW-1:0]        idx_q;
	cell_t                     cell_mem [MAX_CELLS];
	cell_t                     cell_q;
	logic [CELLS_W-1:0]        found_q;
	logic [CELLS_W-1:0]        left_q;
	logic [CELLS_W-1:0]        cursor_q;
	res_t                      res_q;
	logic                      done_q;

	logic                      keep;
	logic                      full;
	logic signed [COORD_W-1:0] pt_coord [3];
	logic signed [COORD_W-1:0] quo_s [3];
	logic signed [SUM_W-1:0]   cell_sum [3];
	logic [COORD_W:0]          d_wide [3];
	logic signed [COORD_W-1:0] off_w [3];
	logic [3*CELLS_W-1:0]      total_w;
	logic [IDX_W-1:0]          idx1_w;
	logic [IDX_W-1:0]          idx2_w;
	logic                      hits_nz;
	cell_t                     acc;
	logic                      cell_we;
	logic [CELL_AW-1:0]        cell_waddr;
	cell_t                     cell_wdata;
	logic                      cell_re;
	logic [CELL_AW-1:0]        cell_raddr;
	logic                      emit;
	res_t                      res_nx;

	logic                      div_start;
	logic                      div_floor;
	logic signed [SUM_W-1:0]   div_dvd [3];
	logic [LEAF_W-1:0]         div_dvs [3];
	logic                      div_done [3];
	logic [COORD_W-1:0]        div_quo [3];

	assign keep = !(cut_en_q && (request.point_distance > cut_dist_q));
	assign full = count_q == CNT_W'(MAX_POINTS);
	assign hits_nz = cell_q.hits != '0;

	assign cell_sum[0] = cell_q.sum_x;
	assign cell_sum[1] = cell_q.sum_y;
	assign cell_sum[2] = cell_q.sum_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pt_coord[a] = pt_q[a*COORD_W +: COORD_W];
			quo_s[a] = div_quo[a];
			d_wide[a] = {hi_q[a][COORD_W-1], hi_q[a]} - {lo_q[a][COORD_W-1], lo_q[a]}
				+ (COORD_W+1)'(1);
			off_w[a] = quo_s[a] - lo_q[a];
		end
	end

	assign total_w = p01_q * dim_q[2];
	assign idx1_w = off_q[2] * dim_q[1] + IDX_W'(off_q[1]);
	assign idx2_w = t_q * dim_q[0] + IDX_W'(off_q[0]);

	assign acc.sum_x = cell_q.sum_x + SUM_W'(pt_coord[0]);
	assign acc.sum_y = cell_q.sum_y + SUM_W'(pt_coord[1]);
	assign acc.sum_z = cell_q.sum_z + SUM_W'(pt_coord[2]);
	assign acc.hits = cell_q.hits + HITS_W'(1);

	// divider lanes, one per axis
	assign div_start = (ctl.op == OP_DIV_PT) || ((ctl.op == OP_CELL_CHECK) && hits_nz);
	assign div_floor = ctl.op == OP_DIV_PT;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (ctl.op == OP_DIV_PT) begin
				div_dvd[a] = SUM_W'(pt_coord[a]);
				div_dvs[a] = leaf_q[a];
			end else begin
				div_dvd[a] = cell_sum[a];
				div_dvs[a] = LEAF_W'(cell_q.hits);
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		vgcd_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.start     (div_start),
			.floor_mode(div_floor),
			.dividend  (div_dvd[g]),
			.divisor   (div_dvs[g]),
			.done      (div_done[g]),
			.quotient  (div_quo[g])
		);
	end

	assign stat.ovf = ovf_q;
	assign stat.cnt_zero = count_q == '0;
	assign stat.pt_last = CNT_W'(n_q) == (count_q - CNT_W'(1));
	assign stat.div_done = div_done[0] && div_done[1] && div_done[2];
	assign stat.grid_big = over_q[0] || over_q[1] || over_q[2]
		|| (p01_q > (2*CELLS_W)'(MAX_CELLS)) || (total_w > (3*CELLS_W)'(MAX_CELLS));
	assign stat.clr_last = clr_q == CELL_AW'(MAX_CELLS - 1);
	assign stat.hits_nz = hits_nz;
	assign stat.scan_more = (cursor_q + CELLS_W'(1)) < total_q;
	assign stat.fetch_empty = (left_q == '0) || (cursor_q >= total_q);

	assign emit = (ctl.op == OP_EOS_FAIL) || (ctl.op == OP_EOS_OK)
		|| (ctl.op == OP_FETCH_EMIT) || (ctl.op == OP_FETCH_NONE);

	always_comb begin
		res_nx = '0;
		unique case (ctl.op)
			OP_EOS_FAIL: begin
				res_nx.result_kind = RK_STATUS;
				res_nx.status = ctl.status;
			end
			OP_EOS_OK: begin
				res_nx.result_kind = RK_STATUS;
				res_nx.status = ST_OK;
				res_nx.centroid_count = found_q;
			end
			OP_FETCH_NONE: begin
				res_nx.result_kind = RK_FETCH;
				res_nx.status = ST_NONE;
			end
			OP_FETCH_EMIT: begin
				res_nx.result_kind = RK_FETCH;
				res_nx.status = ST_OK;
				res_nx.mean_x = quo_s[0];
				res_nx.mean_y = quo_s[1];
				res_nx.mean_z = quo_s[2];
				res_nx.last_centroid = left_q == CELLS_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = res_q;

	// cell memory ports
	assign cell_we = (ctl.op == OP_CLEAR) || (ctl.op == OP_CELL_ACC);
	assign cell_waddr = (ctl.op == OP_CLEAR) ? clr_q : idx_q;
	assign cell_wdata = (ctl.op == OP_CLEAR) ? cell_t'('0) : acc;
	assign cell_re = (ctl.op == OP_CELL_READ_IDX) || (ctl.op == OP_CELL_READ_CUR);
	assign cell_raddr = (ctl.op == OP_CELL_READ_IDX) ? idx_q : cursor_q[CELL_AW-1:0];

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_waddr] <= cell_wdata;
		end
		if (cell_re) begin
			cell_q <= cell_mem[cell_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.op == OP_LOAD) && keep && !full) begin
			pt_mem[count_q[PT_AW-1:0]] <= {request.point_z, request.point_y, request.point_x};
		end
		if (ctl.op == OP_PT_READ) begin
			pt_q <= pt_mem[n_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q[0] <= LEAF_RESET;
			leaf_q[1] <= LEAF_RESET;
			leaf_q[2] <= LEAF_RESET;
			cut_en_q <= 1'b0;
			cut_dist_q <= '1;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_LEAF_X:   leaf_q[0] <= write_data[LEAF_W-1:0];
				REG_LEAF_Y:   leaf_q[1] <= write_data[LEAF_W-1:0];
				REG_LEAF_Z:   leaf_q[2] <= write_data[LEAF_W-1:0];
				REG_CUT_EN:   cut_en_q <= write_data[0];
				REG_CUT_DIST: cut_dist_q <= write_data[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			total_q <= '0;
			found_q <= '0;
			left_q <= '0;
			cursor_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
			unique case (ctl.op)
				OP_LOAD: begin
					if (keep) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				OP_EOS_FAIL: begin
					count_q <= '0;
					ovf_q <= 1'b0;
					total_q <= '0;
					left_q <= '0;
					cursor_q <= '0;
				end
				OP_COMMIT: begin
					total_q <= total_w[CELLS_W-1:0];
					found_q <= '0;
				end
				OP_CELL_ACC: begin
					if (!hits_nz) begin
						found_q <= found_q + CELLS_W'(1);
					end
				end
				OP_EOS_OK: begin
					count_q <= '0;
					ovf_q <= 1'b0;
					left_q <= found_q;
					cursor_q <= '0;
				end
				OP_CELL_CHECK: cursor_q <= cursor_q + CELLS_W'(1);
				OP_FETCH_EMIT: left_q <= left_q - CELLS_W'(1);
				OP_FETCH_NONE: left_q <= '0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_nx;
		end
		unique case (ctl.op)
			OP_PASS_INIT: n_q <= '0;
			OP_BOX_UPD: begin
				for (int a = 0; a < 3; a++) begin
					if ((n_q == '0) || (quo_s[a] < lo_q[a])) begin
						lo_q[a] <= quo_s[a];
					end
					if ((n_q == '0) || (quo_s[a] > hi_q[a])) begin
						hi_q[a] <= quo_s[a];
					end
				end
				n_q <= n_q + PT_AW'(1);
			end
			OP_DIM1: begin
				for (int a = 0; a < 3; a++) begin
					dim_q[a] <= d_wide[a][CELLS_W-1:0];
					over_q[a] <= d_wide[a] > (COORD_W+1)'(MAX_CELLS);
				end
			end
			OP_DIM2: p01_q <= dim_q[0] * dim_q[1];
			OP_COMMIT: begin
				clr_q <= '0;
				n_q <= '0;
			end
			OP_CLEAR: clr_q <= clr_q + CELL_AW'(1);
			OP_OFFSET: begin
				for (int a = 0; a < 3; a++) begin
					off_q[a] <= off_w[a][CELL_AW-1:0];
				end
			end
			OP_IDX1: t_q <= idx1_w[CELL_AW-1:0];
			OP_IDX2: idx_q <= idx2_w[CELL_AW-1:0];
			OP_CELL_ACC: n_q <= n_q + PT_AW'(1);
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/vgcd_ctrl.sv =====
`timescale 1ns / 1ps
module vgcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         command,
	input  vgcd_pkg::dp_stat_t stat,
	output logic               busy,
	output vgcd_pkg::ctl_t     ctl
);
	import vgcd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		ctl.op = OP_NONE;
		ctl.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (command)
						CMD_LOAD: ctl.op = OP_LOAD;
						CMD_END: begin
							if (stat.ovf) begin
								ctl.op = OP_EOS_FAIL;
								ctl.status = ST_OVERFLOW;
							end else if (stat.cnt_zero) begin
								ctl.op = OP_EOS_FAIL;
								ctl.status = ST_EMPTY;
							end else begin
								ctl.op = OP_PASS_INIT;
								state_d = S_B_READ;
							end
						end
						CMD_FETCH: begin
							if (stat.fetch_empty) begin
								ctl.op = OP_FETCH_NONE;
							end else begin
								state_d = S_F_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_B_READ: begin
				ctl.op = OP_PT_READ;
				state_d = S_B_DIV;
			end
			S_B_DIV: begin
				ctl.op = OP_DIV_PT;
				state_d = S_B_WAIT;
			end
			S_B_WAIT: begin
				if (stat.div_done) begin
					ctl.op = OP_BOX_UPD;
					state_d = stat.pt_last ? S_DIM1 : S_B_READ;
				end
			end
			S_DIM1: begin
				ctl.op = OP_DIM1;
				state_d = S_DIM2;
			end
			S_DIM2: begin
				ctl.op = OP_DIM2;
				state_d = S_DIM3;
			end
			S_DIM3: begin
				if (stat.grid_big) begin
					ctl.op = OP_EOS_FAIL;
					ctl.status = ST_GRID;
					state_d = S_IDLE;
				end else begin
					ctl.op = OP_COMMIT;
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				ctl.op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_A_READ;
				end
			end
			S_A_READ: begin
				ctl.op = OP_PT_READ;
				state_d = S_A_DIV;
			end
			S_A_DIV: begin
				ctl.op = OP_DIV_PT;
				state_d = S_A_WAIT;
			end
			S_A_WAIT: begin
				if (stat.div_done) begin
					ctl.op = OP_OFFSET;
					state_d = S_A_IDX1;
				end
			end
			S_A_IDX1: begin
				ctl.op = OP_IDX1;
				state_d = S_A_IDX2;
			end
			S_A_IDX2: begin
				ctl.op = OP_IDX2;
				state_d = S_A_RD;
			end
			S_A_RD: begin
				ctl.op = OP_CELL_READ_IDX;
				state_d = S_A_UPD;
			end
			S_A_UPD: begin
				ctl.op = OP_CELL_ACC;
				state_d = stat.pt_last ? S_A_DONE : S_A_READ;
			end
			S_A_DONE: begin
				ctl.op = OP_EOS_OK;
				state_d = S_IDLE;
			end
			S_F_READ: begin
				ctl.op = OP_CELL_READ_CUR;
				state_d = S_F_CHECK;
			end
			S_F_CHECK: begin
				ctl.op = OP_CELL_CHECK;
				if (stat.hits_nz) begin
					state_d = S_F_WAIT;
				end else if (stat.scan_more) begin
					state_d = S_F_READ;
				end else begin
					state_d = S_F_NONE;
				end
			end
			S_F_WAIT: begin
				if (stat.div_done) begin
					ctl.op = OP_FETCH_EMIT;
					state_d = S_IDLE;
				end
			end
			S_F_NONE: begin
				ctl.op = OP_FETCH_NONE;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/voxel_grid_centroid_downsample.sv =====
`timescale 1ns / 1ps
// Voxel-grid centroid downsampler. A request is taken when start is high and busy is low.
// Load requests never raise busy, so points can stream one per clock. End of set runs
// two passes over the N stored points, each point costing one 43-step restoring
// division per axis (three lanes in parallel): a bounding-box pass, then sizing the
// grid, clearing the cell memory and a binning pass; an overflowed or empty set answers
// at once, a grid that is too large answers once the grid is sized, before any clear.
// A fetch scans the cell memory cell by cell from the last position and then divides
// the sums of the cell it finds. Each answer appears on result for exactly one
// cycle with done high and must be taken then; there is no way to hold it off.
// Configuration is to be written only while the block is idle; nothing in the block
// itself enforces this.
module voxel_grid_centroid_downsample (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  vgcd_pkg::req_t                   request,
	output logic                             busy,
	output logic                             done,
	output vgcd_pkg::res_t                   result,
	input  logic                             write_enable,
	input  logic [vgcd_pkg::REG_IDX_W-1:0]   reg_index,
	input  logic [vgcd_pkg::CFG_W-1:0]       write_data
);
	import vgcd_pkg::*;

	ctl_t     ctl;
	dp_stat_t stat;

	vgcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(request.command),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	vgcd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.ctl         (ctl),
		.write_enable(write_enable),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.stat        (stat),
		.done        (done),
		.result      (result)
	);

`ifndef SYNTH
	a_result_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command == CMD_LOAD)) |=> !done)
		else $error("load request produced a result");

	a_last_is_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.last_centroid) |->
		((result.result_kind == RK_FETCH) && (result.status == ST_OK)))
		else $error("last centroid flag on a non-centroid result");
`endif

endmodule

// ===== verif/vgcd_checker.sv =====
`timescale 1ns / 1ps
module vgcd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  vgcd_pkg::req_t                 request,
	input  logic                           busy,
	input  logic                           done,
	input  vgcd_pkg::res_t                 result,
	input  logic                           write_enable,
	input  logic [vgcd_pkg::REG_IDX_W-1:0] reg_index,
	input  logic [vgcd_pkg::CFG_W-1:0]     write_data,
	output int                             mismatches,
	output int                             outstanding,
	output int                             answers_seen
);
	import vgcd_pkg::*;

	logic [LEAF_W-1:0]         leaf [3];
	logic                      cut_on;
	logic [COORD_W-1:0]        cut_limit;
	logic signed [COORD_W-1:0] pts [MAX_POINTS][3];
	int                        n_stored;
	logic                      ovf;
	longint                    box_lo [3];
	longint                    cpa [3];
	longint                    sums [MAX_CELLS][3];
	int                        hits [MAX_CELLS];
	longint                    cursor;
	int                        left;
	int                        fails;
	int                        answers;
	res_t                      expected_answers [$];

	function automatic longint floor_cell(longint p, logic [LEAF_W-1:0] l);
		longint d, q;
		d = (l == 0) ? 1 : longint'(l);
		q = p / d;
		if ((p % d) != 0 && p < 0)
			q--;
		return q;
	endfunction

	function automatic void close_set(output logic [2:0] st, output int found);
		longint lo [3], hi [3], c, d, total, idx;
		bit big;
		left = 0;
		cursor = 0;
		found = 0;
		for (int a = 0; a < 3; a++)
			cpa[a] = 0;
		if (ovf) begin
			st = ST_OVERFLOW;
			return;
		end
		if (n_stored == 0) begin
			st = ST_EMPTY;
			return;
		end
		for (int a = 0; a < 3; a++) begin
			lo[a] = 64'sh7fffffffffffffff;
			hi[a] = -64'sh7fffffffffffffff - 1;
		end
		for (int n = 0; n < n_stored; n++)
			for (int a = 0; a < 3; a++) begin
				c = floor_cell(longint'(pts[n][a]), leaf[a]);
				if (c < lo[a]) lo[a] = c;
				if (c > hi[a]) hi[a] = c;
			end
		total = 1;
		big = 0;
		for (int a = 0; a < 3 && !big; a++) begin
			d = hi[a] - lo[a] + 1;
			if (d > MAX_CELLS)
				big = 1;
			else begin
				total *= d;
				if (total > MAX_CELLS) big = 1;
			end
		end
		if (big) begin
			st = ST_GRID;
			return;
		end
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = lo[a];
			cpa[a] = hi[a] - lo[a] + 1;
		end
		for (int i = 0; i < MAX_CELLS; i++) begin
			hits[i] = 0;
			for (int a = 0; a < 3; a++)
				sums[i][a] = 0;
		end
		for (int n = 0; n < n_stored; n++) begin
			idx = 0;
			for (int a = 2; a >= 0; a--)
				idx = idx * cpa[a] + (floor_cell(longint'(pts[n][a]), leaf[a]) - lo[a]);
			if (idx < MAX_CELLS) begin
				if (hits[idx] == 0) found++;
				for (int a = 0; a < 3; a++)
					sums[idx][a] += longint'(pts[n][a]);
				hits[idx]++;
			end
		end
		left = found;
		st = ST_OK;
	endfunction

	function automatic res_t next_centroid();
		res_t r;
		longint total;
		int c;
		r = '0;
		r.result_kind = RK_FETCH;
		total = cpa[0] * cpa[1] * cpa[2];
		if (total > MAX_CELLS) total = MAX_CELLS;
		while (left > 0 && cursor < total) begin
			c = int'(cursor);
			cursor++;
			if (hits[c] > 0) begin
				left--;
				r.status = ST_OK;
				r.mean_x = COORD_W'(sums[c][0] / hits[c]);
				r.mean_y = COORD_W'(sums[c][1] / hits[c]);
				r.mean_z = COORD_W'(sums[c][2] / hits[c]);
				r.last_centroid = (left == 0);
				return r;
			end
		end
		left = 0;
		r.status = ST_NONE;
		return r;
	endfunction

	function automatic void take_request(req_t q);
		res_t r;
		logic [2:0] st;
		int found;
		case (q.command)
			CMD_LOAD: begin
				if (!(cut_on && q.point_distance > cut_limit)) begin
					if (n_stored >= MAX_POINTS)
						ovf = 1;
					else begin
						pts[n_stored][0] = q.point_x;
						pts[n_stored][1] = q.point_y;
						pts[n_stored][2] = q.point_z;
						n_stored++;
					end
				end
			end
			CMD_END: begin
				close_set(st, found);
				r = '0;
				r.result_kind = RK_STATUS;
				r.status = st;
				r.centroid_count = (st == ST_OK) ? CELLS_W'(found) : '0;
				expected_answers.push_back(r);
				n_stored = 0;
				ovf = 0;
			end
			CMD_FETCH: expected_answers.push_back(next_centroid());
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t e;
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				leaf[a] = LEAF_RESET;
				cpa[a] = 0;
				box_lo[a] = 0;
			end
			cut_on = 0;
			cut_limit = '1;
			n_stored = 0;
			ovf = 0;
			cursor = 0;
			left = 0;
			fails = 0;
			answers = 0;
			expected_answers.delete();
		end else begin
			if (done) begin
				answers++;
				if (expected_answers.size() == 0) begin
					fails++;
					$display("%0t: unexpected answer %p", $time, result);
				end else begin
					e = expected_answers.pop_front();
					if (result.result_kind !== e.result_kind || result.status !== e.status ||
					    result.centroid_count !== e.centroid_count ||
					    result.mean_x !== e.mean_x || result.mean_y !== e.mean_y ||
					    result.mean_z !== e.mean_z ||
					    result.last_centroid !== e.last_centroid) begin
						fails++;
						$display("%0t: mismatch expected %p actual %p", $time, e, result);
					end
				end
			end
			if (write_enable) begin
				case (reg_index)
					REG_LEAF_X:   leaf[0] = write_data[LEAF_W-1:0];
					REG_LEAF_Y:   leaf[1] = write_data[LEAF_W-1:0];
					REG_LEAF_Z:   leaf[2] = write_data[LEAF_W-1:0];
					REG_CUT_EN:   cut_on = write_data[0];
					REG_CUT_DIST: cut_limit = write_data;
					default: ;
				endcase
			end
			if (start && !busy)
				take_request(request);
		end
		mismatches <= fails;
		outstanding <= expected_answers.size();
		answers_seen <= answers;
	end
endmodule

// ===== verif/tb_voxel_grid_centroid_downsample.sv =====
`timescale 1ns / 1ps
module tb_voxel_grid_centroid_downsample;
	import vgcd_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	req_t                 request;
	logic                 busy;
	logic                 done;
	res_t                 result;
	logic                 write_enable;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     write_data;
	int                   mismatches, outstanding, answers_seen;
	int                   items, sets;
	bit                   gaps_on;

	voxel_grid_centroid_downsample dut (
		.clk, .arst_n, .start, .request, .busy, .done, .result,
		.write_enable, .reg_index, .write_data
	);

	vgcd_checker chk (
		.clk, .arst_n, .start, .request, .busy, .done, .result,
		.write_enable, .reg_index, .write_data,
		.mismatches, .outstanding, .answers_seen
	);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	task automatic send(logic [1:0] cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
	                    logic [31:0] d);
		start <= 1;
		request <= '{command: cmd, point_x: x, point_y: y, point_z: z, point_distance: d};
		do @(posedge clk); while (busy);
		if (cmd != CMD_SPARE) items++;
		if (gaps_on && $urandom_range(0, 6) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic cmd_only(logic [1:0] cmd);
		send(cmd, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		write_enable <= 1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic [30:0] lx, logic [30:0] ly, logic [30:0] lz, bit cut,
	                          logic [31:0] lim);
		settle();
		write_reg(REG_LEAF_X, {1'($urandom), lx});
		write_reg(REG_LEAF_Y, {1'($urandom), ly});
		write_reg(REG_LEAF_Z, {1'($urandom), lz});
		write_reg(REG_CUT_EN, {31'($urandom), cut});
		write_reg(REG_CUT_DIST, lim);
		write_enable <= 0;
	endtask

	function automatic logic [30:0] pick_leaf();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 31'($urandom_range(1, 255));
			2: return 31'h7fffffff;
			3: return 31'($urandom);
			default: return 31'(1) << $urandom_range(8, 24);
		endcase
	endfunction

	function automatic logic [31:0] near(longint base, longint l, int span);
		longint v;
		v = base + (longint'({1'b0, 31'($urandom), 32'($urandom)}) % (l * span));
		if (v > 64'sh7fffffff) v = 64'sh7fffffff;
		return 32'(v);
	endfunction

	initial begin : timeout
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stim
		logic [30:0] lf [3];
		longint base [3], l [3];
		int span [3];
		int npts, nfetch;
		bit cut, noisy;
		logic [31:0] lim, d;
		arst_n = 0;
		start = 0;
		request = '0;
		write_enable = 0;
		reg_index = '0;
		write_data = '0;
		items = 0;
		sets = 0;
		gaps_on = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// nothing stored yet
		cmd_only(CMD_FETCH);
		cmd_only(CMD_END);
		cmd_only(CMD_SPARE);
		cmd_only(CMD_FETCH);
		// corners of the coordinate range: grid far too large
		send(CMD_LOAD, 32'h80000000, 32'h80000000, 32'h80000000, '1);
		send(CMD_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		cmd_only(CMD_END);
		cmd_only(CMD_FETCH);
		// corners with the widest leaf: tiny grid, negative floors
		set_config(31'h7fffffff, 31'h7fffffff, 0, 0, '1);
		send(CMD_LOAD, 32'h80000000, 32'h7fffffff, 32'h00000000, 0);
		send(CMD_LOAD, 32'h7fffffff, 32'h80000000, 32'hffffffff, '1);
		send(CMD_LOAD, 32'hffffffff, 32'h00000001, 32'h00000002, 5);
		cmd_only(CMD_END);
		repeat (4) cmd_only(CMD_FETCH);
		// distance cut, kept when equal
		set_config(31'h10000, 31'h10000, 31'h10000, 1, 32'h00050000);
		send(CMD_LOAD, 32'h00018000, 32'hfffe8000, 32'h0, 32'h00050000);
		send(CMD_LOAD, 32'h00010000, 32'hffff0000, 32'h0, 32'h00050001);
		send(CMD_LOAD, 32'h00012345, 32'hffffffff, 32'h0, 0);
		cmd_only(CMD_END);
		repeat (3) cmd_only(CMD_FETCH);
		// every point cut: empty set
		send(CMD_LOAD, 32'h0, 32'h0, 32'h0, '1);
		cmd_only(CMD_END);
		// buffer overflow
		set_config(31'h10000, 31'h10000, 31'h10000, 0, '1);
		for (int i = 0; i < MAX_POINTS + 3; i++)
			send(CMD_LOAD, $urandom_range(0, 32'h3ffff), $urandom_range(0, 32'h3ffff), 0,
			     $urandom);
		cmd_only(CMD_END);
		cmd_only(CMD_FETCH);

		while (items < 1450) begin
			gaps_on = (items < 1250);
			for (int a = 0; a < 3; a++) begin
				lf[a] = pick_leaf();
				l[a] = (lf[a] == 0) ? 1 : longint'(lf[a]);
				span[a] = $urandom_range(1, 12);
				base[a] = longint'(signed'(32'($urandom)));
			end
			cut = ($urandom_range(0, 2) == 0);
			lim = $urandom;
			set_config(lf[0], lf[1], lf[2], cut, lim);
			sets++;
			case ($urandom_range(0, 29))
				0: npts = 0;
				1, 2: npts = $urandom_range(40, 120);
				default: npts = $urandom_range(1, 16);
			endcase
			noisy = ($urandom_range(0, 24) == 0);
			if ($urandom_range(0, 9) == 0) cmd_only(CMD_FETCH);
			for (int i = 0; i < npts; i++) begin
				if ($urandom_range(0, 19) == 0) cmd_only(CMD_SPARE);
				d = $urandom_range(0, 1) ? $urandom : lim;
				if (noisy)
					send(CMD_LOAD, $urandom, $urandom, $urandom, d);
				else
					send(CMD_LOAD, near(base[0], l[0], span[0]), near(base[1], l[1], span[1]),
					     near(base[2], l[2], span[2]), d);
			end
			cmd_only(CMD_END);
			nfetch = ($urandom_range(0, 4) != 0) ? npts + 1 : $urandom_range(0, npts);
			for (int i = 0; i < nfetch; i++)
				cmd_only(CMD_FETCH);
		end

		start <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d random sets, %0d answers checked", sets, answers_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
